// ===== hw/rtl/dtf_pkg.sv =====
// shared constants, types and helper functions for the decimal text parser
`timescale 1ns / 1ps
package dtf_pkg;

  localparam int INT_BITS        = 16;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;

  localparam int VALUE_W    = 32;
  localparam int CH_W       = 8;
  localparam int INT_ACC_W  = INT_BITS - 1;
  localparam int FRAC_ACC_W = $clog2(10 ** MAX_FRAC_DIGITS);
  localparam int FCNT_W     = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int QCNT_W     = $clog2(FRAC_BITS + 1);

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CH_W-1:0] CH_POINT = 8'h2e;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic                  in_digits;
    logic                  negative;
    logic                  point_seen;
    logic [INT_ACC_W-1:0]  int_accum;
    logic                  int_clamped;
    logic [FRAC_ACC_W-1:0] frac_accum;
    logic [FCNT_W-1:0]     frac_count;
  } acc_state_t;

  typedef struct packed {
    logic            take;
    logic            clear;
    logic [CH_W-1:0] ch;
  } acc_cmd_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // true when the character closes the number (and yields a request)
  function automatic logic ends_number(input logic in_digits, input logic [CH_W-1:0] c);
    logic cont;
    if (in_digits) begin
      cont = is_digit(c) || (c == CH_POINT);
    end else begin
      cont = is_digit(c) || (c == CH_POINT) || (c == CH_SPACE) || (c == CH_TAB) ||
             (c == CH_MINUS) || (c == CH_PLUS);
    end
    return !cont;
  endfunction

  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
    logic [3:0]  n4;
    logic [63:0] p;
    n4 = 4'(n);
    case (n4)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      default: p = 64'd1;
    endcase
    return p[FRAC_ACC_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/dtf_if.sv =====
// request channel interfaces: character input and fixed-point result
`timescale 1ns / 1ps
interface dtf_in_if;
  import dtf_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface dtf_out_if;
  import dtf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      saturated;
  modport source (output valid, output value, output saturated, input ready);
  modport sink (input valid, input value, input saturated, output ready);
endinterface

// ===== hw/rtl/decimal_text_to_fixed_parser.sv =====
// top level: character intake, sequencer and result register
`timescale 1ns / 1ps
// Parses ASCII decimal text, one character per request, into signed Q16.16.
// Leading spaces and tabs are skipped, one optional sign is taken, then digits
// with an optional point; later points are ignored and fraction digits past
// the ninth are dropped. The first character that cannot continue the number
// is consumed and produces one result; an integer part above 32767 is clamped
// and flags saturated. A character that does not end a number leaves the input
// ready for the next one. A terminating character starts the fraction scaling
// in a restoring divider that retires one quotient bit per cycle, and the
// input is held off until the result has moved into the output register,
// which may still be waiting on the sink.
module decimal_text_to_fixed_parser (
  input  logic      clk,
  input  logic      rst_n,
  dtf_in_if.sink    in_chan,
  dtf_out_if.source out_chan
);
  import dtf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] value_r;
  logic                      sat_r;
  acc_cmd_t                  cmd;
  acc_state_t                acc;
  logic                      in_fire;
  logic                      term;
  logic                      div_done;
  logic [FRAC_BITS-1:0]      quot;
  logic                      load_out;
  logic [63:0]               mag;
  logic [63:0]               sval;

  assign in_chan.ready      = (state_r == S_IDLE);
  assign in_fire            = in_chan.valid && in_chan.ready;
  assign term               = ends_number(acc.in_digits, in_chan.ch);
  assign load_out           = (state_r == S_DIV) && div_done &&
                              (!out_valid_r || out_chan.ready);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.value     = value_r;
  assign out_chan.saturated = sat_r;

  always_comb begin
    cmd.take  = in_fire && !term;
    cmd.clear = load_out;
    cmd.ch    = in_chan.ch;
  end

  dtf_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .st    (acc)
  );

  dtf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire && term),
    .num   (acc.frac_accum),
    .den   (pow10(acc.frac_count)),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    mag  = (64'(acc.int_accum) << FRAC_BITS) + 64'(quot);
    sval = acc.negative ? (64'd0 - mag) : mag;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && term) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (load_out) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value_r <= sval[VALUE_W-1:0];
      sat_r   <= acc.int_clamped;
    end
  end

endmodule

// ===== hw/rtl/dtf_accum.sv =====
// number state: phase flags, integer and fraction digit accumulators
`timescale 1ns / 1ps
module dtf_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  dtf_pkg::acc_cmd_t   cmd,
  output dtf_pkg::acc_state_t st
);
  import dtf_pkg::*;

  acc_state_t st_r, st_nxt;
  logic [3:0]             dig;
  logic [INT_ACC_W+3:0]   int_next;
  logic [FRAC_ACC_W+3:0]  frac_next;
  logic                   digit_c;
  logic                   point_c;
  logic                   proc;

  assign st = st_r;

  always_comb begin
    dig       = 4'(cmd.ch - CH_ZERO);
    int_next  = ((INT_ACC_W+4)'(st_r.int_accum) << 3) + ((INT_ACC_W+4)'(st_r.int_accum) << 1)
                + (INT_ACC_W+4)'(dig);
    frac_next = ((FRAC_ACC_W+4)'(st_r.frac_accum) << 3)
                + ((FRAC_ACC_W+4)'(st_r.frac_accum) << 1) + (FRAC_ACC_W+4)'(dig);
    digit_c   = is_digit(cmd.ch);
    point_c   = (cmd.ch == CH_POINT);
    st_nxt    = st_r;
    proc      = 1'b0;
    if (cmd.clear) begin
      st_nxt = '0;
    end else if (cmd.take) begin
      if (!st_r.in_digits) begin
        if (cmd.ch == CH_MINUS) begin
          st_nxt.negative  = 1'b1;
          st_nxt.in_digits = 1'b1;
        end else if (cmd.ch == CH_PLUS) begin
          st_nxt.in_digits = 1'b1;
        end else if (digit_c || point_c) begin
          st_nxt.in_digits = 1'b1;
          proc             = 1'b1;
        end
      end else begin
        proc = 1'b1;
      end
      if (proc && digit_c) begin
        if (!st_r.point_seen) begin
          // anything above the top field bits is past the integer limit
          if (int_next[INT_ACC_W+3:INT_ACC_W] != 4'd0) begin
            st_nxt.int_accum   = {INT_ACC_W{1'b1}};
            st_nxt.int_clamped = 1'b1;
          end else begin
            st_nxt.int_accum = int_next[INT_ACC_W-1:0];
          end
        end else if (st_r.frac_count < FCNT_W'(MAX_FRAC_DIGITS)) begin
          st_nxt.frac_accum = frac_next[FRAC_ACC_W-1:0];
          st_nxt.frac_count = st_r.frac_count + FCNT_W'(1);
        end
      end else if (proc && point_c) begin
        st_nxt.point_seen = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== hw/rtl/dtf_div.sv =====
// restoring divider, one quotient bit per cycle: frac * 2^FRAC_BITS / 10^count
`timescale 1ns / 1ps
module dtf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [dtf_pkg::FRAC_ACC_W-1:0]   num,
  input  logic [dtf_pkg::FRAC_ACC_W-1:0]   den,
  output logic                             done,
  output logic [dtf_pkg::FRAC_BITS-1:0]    quot
);
  import dtf_pkg::*;

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FRAC_ACC_W-1:0] rem_r, rem_nxt;
  logic [FRAC_ACC_W-1:0] den_r, den_nxt;
  logic [FRAC_BITS-1:0]  quot_r, quot_nxt;
  logic [FRAC_ACC_W:0]   shifted;
  logic [FRAC_ACC_W:0]   diff;
  logic                  ge;

  assign done = done_r;
  assign quot = quot_r;

  always_comb begin
    // remainder stays below the divisor, so the doubled value fits one extra bit
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, den_r};
    ge       = (shifted >= {1'b0, den_r});
    run_nxt  = run_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start) begin
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = QCNT_W'(FRAC_BITS);
      rem_nxt  = num;
      den_nxt  = den;
      quot_nxt = '0;
    end else if (run_r) begin
      rem_nxt  = ge ? diff[FRAC_ACC_W-1:0] : shifted[FRAC_ACC_W-1:0];
      quot_nxt = {quot_r[FRAC_BITS-2:0], ge};
      cnt_nxt  = cnt_r - QCNT_W'(1);
      if (cnt_r == QCNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the decimal text parser: character stimulus, Q16.16 prediction and checks
`timescale 1ns / 1ps
module tb_top;
  import dtf_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam longint unsigned WHOLE_MAX = (64'd1 << (INT_BITS - 1)) - 1;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;
  } fixed_result_t;

  // tracks the number being typed and queues the fixed-point value each terminator yields
  class fixed_value_board;
    fixed_result_t     waiting[$];
    bit                in_number;
    bit                minus;
    bit                point;
    bit                clamped;
    longint unsigned   whole;
    longint unsigned   frac_digits;
    int unsigned       frac_len;
    int                errors;
    int                results;
    int                saturations;
    int                negatives;

    function new();
      clear();
    endfunction

    function void clear();
      in_number   = 0;
      minus       = 0;
      point       = 0;
      clamped     = 0;
      whole       = 0;
      frac_digits = 0;
      frac_len    = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void close_number();
      fixed_result_t   r;
      longint unsigned divisor;
      longint unsigned mag;
      divisor = 1;
      for (int k = 0; k < frac_len; k++) divisor = divisor * 10;
      // fraction truncated before the sign goes on
      mag = (whole << FRAC_BITS) + ((frac_digits << FRAC_BITS) / divisor);
      if (minus) mag = 64'd0 - mag;
      r.value     = mag[VALUE_W-1:0];
      r.saturated = clamped;
      waiting.push_back(r);
      results++;
      if (clamped) saturations++;
      if (minus) negatives++;
      clear();
    endfunction

    function void note_char(logic [CH_W-1:0] c);
      bit digit;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (!in_number && (c == CH_SPACE || c == CH_TAB)) return;
      if (!in_number && (c == CH_MINUS || c == CH_PLUS)) begin
        minus     = (c == CH_MINUS);
        in_number = 1;
        return;
      end
      if (digit || c == CH_POINT) begin
        in_number = 1;
        if (c == CH_POINT) begin
          point = 1;
        end else if (!point) begin
          whole = whole * 10 + (c - CH_ZERO);
          if (whole > WHOLE_MAX) begin
            whole   = WHOLE_MAX;
            clamped = 1;
          end
        end else if (frac_len < MAX_FRAC_DIGITS) begin
          frac_digits = frac_digits * 10 + (c - CH_ZERO);
          frac_len++;
        end
      end else begin
        close_number();
      end
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] v, logic s);
      fixed_result_t e;
      if (waiting.size() == 0) begin
        flag($sformatf("unexpected result value %h saturated %0b", v, s));
        return;
      end
      e = waiting.pop_front();
      if (v !== e.value)
        flag($sformatf("value mismatch: expected %h got %h", e.value, v));
      if (s !== e.saturated)
        flag($sformatf("saturated mismatch: expected %0b got %0b", e.saturated, s));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_requests;
  int   chars_sent;

  fixed_value_board board;

  dtf_in_if  in_chan ();
  dtf_out_if out_chan ();

  decimal_text_to_fixed_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_char(input logic [CH_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    board.note_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
  endtask

  function automatic logic [CH_W-1:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  task automatic send_end_char();
    logic [CH_W-1:0] c;
    do c = 8'($urandom_range(255)); while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT);
    send_char(c);
  endtask

  task automatic send_random_text();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // raw noise bytes
      n = $urandom_range(1, 3);
      repeat (n) send_char(8'($urandom_range(255)));
    end else if (pick < 20) begin
      // signs and points with no digits
      if ($urandom_range(1)) send_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
      n = $urandom_range(2);
      repeat (n) send_char(CH_POINT);
      send_end_char();
    end else begin
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
      n = $urandom_range(2);
      if (n == 1) send_char(CH_MINUS);
      else if (n == 2) send_char(CH_PLUS);
      if (pick < 28) begin
        // right around the clamp point
        send_text($sformatf("%0d", 32760 + $urandom_range(15)));
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 4);
        repeat (n) send_char(rand_digit());
      end
      if ($urandom_range(9) < 7) begin
        send_char(CH_POINT);
        n = ($urandom_range(6) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(19) == 0) send_char(CH_POINT);
          send_char(rand_digit());
        end
      end
      send_end_char();
    end
  endtask

  task automatic send_random_chars(input int count);
    int stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) send_random_text();
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (board.waiting.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        board.check_result(out_chan.value, out_chan.saturated);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without a request moving", quiet);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    chars_sent     = 0;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.ch    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: whitespace and sign, sign as terminator, start-phase junk,
    // empty number with extra points, clamp with too many fraction digits
    send_text(" \t-7.5+");
    send_text("x");
    send_text("+..");
    send_char(8'hff);
    send_text("-70000.1234567891");
    send_char(8'h00);
    wait_drained();

    send_random_chars(125);
    wait_drained();

    send_idle_pct = 81;
    send_random_chars(125);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 81;
    send_random_chars(125);
    wait_drained();

    send_idle_pct  = 27;
    recv_stall_pct = 27;
    send_random_chars(125);
    wait_drained();

    // result side blocked while characters keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    send_random_chars(50);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.waiting.size() != 0) begin
      $display("%0d expected results never arrived", board.waiting.size());
      board.errors += board.waiting.size();
    end
    $display("sent %0d characters, checked %0d numbers (%0d negative, %0d clamped)",
             chars_sent, board.results, board.negatives, board.saturations);
    $display("mixes: free flow, sparse input, stalled output, both, and a 400-cycle hold");
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total", board.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
